// ----- rtl/dapt_pkg.sv -----
// dapt_pkg: shared widths, codes, reset values and the lane result type
// for the dual-axis pi tracking controller. No dependencies.
`timescale 1ns / 1ps

package dapt_pkg;

   // defaults for the top-level parameters
   localparam int ANGLE_FRAC_BITS_DEF = 7;
   localparam int INTEGRAL_WIDTH_DEF  = 40;

   // field and datapath widths
   localparam int AZ_W      = 16;
   localparam int PITCH_W   = 15;
   localparam int OFFSET_W  = 17;
   localparam int GAIN_W    = 32;
   localparam int ERR_W     = 18;
   localparam int SPD_W     = 7;
   localparam int DIR_W     = 2;
   localparam int NUM_W     = 7;
   localparam int Q_FRAC    = 24;
   localparam int CSR_IDX_W = 3;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 24;

   // request field positions
   localparam int REQ_TGT_AZ_LSB  = 0;
   localparam int REQ_STD_AZ_LSB  = 16;
   localparam int REQ_TGT_PT_LSB  = 32;
   localparam int REQ_STD_PT_LSB  = 47;

   // result field positions
   localparam int RSP_AZ_DIR_LSB = 0;
   localparam int RSP_AZ_SPD_LSB = 2;
   localparam int RSP_PT_DIR_LSB = 9;
   localparam int RSP_PT_SPD_LSB = 11;
   localparam int RSP_ALIGN_BIT  = 18;

   // per-axis scaling of the proportional term and speed limits
   localparam int AZ_P_NUM     = 127;
   localparam int AZ_P_DEN     = 360;
   localparam int AZ_SPEED_MAX = 127;
   localparam int PT_P_NUM     = 110;
   localparam int PT_P_DEN     = 90;
   localparam int PT_SPEED_MAX = 90;

   localparam int HALF_TURN_DEG = 180;
   localparam int ALIGN_DEG     = 3;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP_AZ  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_AZ  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_PT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_PT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 3'd4;

   // configuration reset values
   localparam logic [GAIN_W-1:0]          KP_AZ_RESET  = 32'd167772160;
   localparam logic [GAIN_W-1:0]          KI_AZ_RESET  = 32'd0;
   localparam logic [GAIN_W-1:0]          KP_PT_RESET  = 32'd41943040;
   localparam logic [GAIN_W-1:0]          KI_PT_RESET  = 32'd0;
   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd1280;

   // what one lane hands to the merge stage
   typedef struct packed {
      logic                    valid;
      logic [SPD_W-1:0]        speed;
      logic signed [ERR_W-1:0] err;
   } lane_res_type;

   // magnitude of an angle error
   function automatic logic [ERR_W-1:0] err_mag(input logic signed [ERR_W-1:0] e);
      logic [ERR_W-1:0] neg;
      neg = ERR_W'(-e);
      return e[ERR_W-1] ? neg : e;
   endfunction

endpackage

// ----- rtl/dual_axis_pi_tracking_controller.sv -----
// dual_axis_pi_tracking_controller: top level - configuration registers,
// error formation, two pi lanes and the merge stage. Uses dapt_pkg,
// dapt_lane and dapt_merge.
`timescale 1ns / 1ps

// One request transaction carries a target and a measured azimuth and
// pitch; one response transaction returns per-axis direction and speed
// plus an aligned flag. The two axes run in parallel lanes, each keeping
// its own saturating integrator. From acceptance an item passes through
// the integral increment, the accumulate and the proportional product,
// four 16-bit digit steps dividing that product by its constant
// denominator, the speed sum and the move of the result into the output
// register. req_tready drops while the lanes work and returns once the
// result moves into the output register, so the block takes no new item
// before the previous one has left the lanes, and a new item can enter
// while the previous result still waits.
// Configuration writes take effect at once and belong to idle periods.

module dual_axis_pi_tracking_controller #(
   parameter int ANGLE_FRAC_BITS = dapt_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int INTEGRAL_WIDTH  = dapt_pkg::INTEGRAL_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // target_azimuth, stand_azimuth, target_pitch, stand_pitch, zero pad
   input  logic [dapt_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // azimuth_direction, azimuth_speed, pitch_direction, pitch_speed,
   // aligned, zero pad
   output logic [dapt_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_we,
   input  logic [dapt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dapt_pkg::GAIN_W-1:0]           csr_wdata
);
   import dapt_pkg::*;

   logic [GAIN_W-1:0]          kp_az_ff, kp_az_in;
   logic [GAIN_W-1:0]          ki_az_ff, ki_az_in;
   logic [GAIN_W-1:0]          kp_pt_ff, kp_pt_in;
   logic [GAIN_W-1:0]          ki_pt_ff, ki_pt_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic                       busy_ff, busy_in;

   logic                       req_acc;
   logic                       take;
   logic [AZ_W-1:0]            tgt_az, std_az;
   logic [PITCH_W-1:0]         tgt_pt, std_pt;
   logic signed [ERR_W-1:0]    err_az_c, err_pt_c;
   lane_res_type               az_res, pt_res;

   // configuration writes
   always_comb begin
      kp_az_in  = kp_az_ff;
      ki_az_in  = ki_az_ff;
      kp_pt_in  = kp_pt_ff;
      ki_pt_in  = ki_pt_ff;
      offset_in = offset_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KP_AZ:  kp_az_in  = csr_wdata;
            CSR_KI_AZ:  ki_az_in  = csr_wdata;
            CSR_KP_PT:  kp_pt_in  = csr_wdata;
            CSR_KI_PT:  ki_pt_in  = csr_wdata;
            CSR_OFFSET: offset_in = csr_wdata[OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_az_ff  <= KP_AZ_RESET;
         ki_az_ff  <= KI_AZ_RESET;
         kp_pt_ff  <= KP_PT_RESET;
         ki_pt_ff  <= KI_PT_RESET;
         offset_ff <= OFFSET_RESET;
      end else begin
         kp_az_ff  <= kp_az_in;
         ki_az_ff  <= ki_az_in;
         kp_pt_ff  <= kp_pt_in;
         ki_pt_ff  <= ki_pt_in;
         offset_ff <= offset_in;
      end
   end

   // lanes busy from acceptance until the result reaches the output register
   assign req_tready = !busy_ff;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      busy_in = busy_ff;
      if (req_acc) begin
         busy_in = 1'b1;
      end else if (take) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // axis errors
   always_comb begin
      tgt_az   = req_tdata[REQ_TGT_AZ_LSB +: AZ_W];
      std_az   = req_tdata[REQ_STD_AZ_LSB +: AZ_W];
      tgt_pt   = req_tdata[REQ_TGT_PT_LSB +: PITCH_W];
      std_pt   = req_tdata[REQ_STD_PT_LSB +: PITCH_W];
      err_az_c = {{(ERR_W - AZ_W){1'b0}}, tgt_az} - {{(ERR_W - AZ_W){1'b0}}, std_az}
                 + {{(ERR_W - OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff};
      err_pt_c = {{(ERR_W - PITCH_W){tgt_pt[PITCH_W-1]}}, tgt_pt}
                 - {{(ERR_W - PITCH_W){std_pt[PITCH_W-1]}}, std_pt};
   end

   dapt_lane #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .INTEGRAL_WIDTH  (INTEGRAL_WIDTH),
      .P_NUM           (AZ_P_NUM),
      .P_DEN           (AZ_P_DEN),
      .SPEED_LIMIT     (AZ_SPEED_MAX)
   ) u_lane_az (
      .clock     (clock),
      .reset     (reset),
      .start     (req_acc),
      .start_err (err_az_c),
      .kp        (kp_az_ff),
      .ki        (ki_az_ff),
      .take      (take),
      .res       (az_res)
   );

   dapt_lane #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .INTEGRAL_WIDTH  (INTEGRAL_WIDTH),
      .P_NUM           (PT_P_NUM),
      .P_DEN           (PT_P_DEN),
      .SPEED_LIMIT     (PT_SPEED_MAX)
   ) u_lane_pt (
      .clock     (clock),
      .reset     (reset),
      .start     (req_acc),
      .start_err (err_pt_c),
      .kp        (kp_pt_ff),
      .ki        (ki_pt_ff),
      .take      (take),
      .res       (pt_res)
   );

   dapt_merge #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .az_res     (az_res),
      .pt_res     (pt_res),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/dapt_lane.sv -----
// dapt_lane: one pi axis core - integrator update, proportional term with
// a chunked reciprocal division by its constant, speed sum, clamp and
// deadband. Uses dapt_pkg.
`timescale 1ns / 1ps

module dapt_lane #(
   parameter int ANGLE_FRAC_BITS = dapt_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int INTEGRAL_WIDTH  = dapt_pkg::INTEGRAL_WIDTH_DEF,
   parameter int P_NUM           = dapt_pkg::AZ_P_NUM,
   parameter int P_DEN           = dapt_pkg::AZ_P_DEN,
   parameter int SPEED_LIMIT     = dapt_pkg::AZ_SPEED_MAX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [dapt_pkg::ERR_W-1:0]   start_err,
   input  logic [dapt_pkg::GAIN_W-1:0]         kp,
   input  logic [dapt_pkg::GAIN_W-1:0]         ki,
   input  logic                                take,
   output dapt_pkg::lane_res_type              res
);
   import dapt_pkg::*;

   localparam int IW      = INTEGRAL_WIDTH;
   localparam int INC_W   = ERR_W + GAIN_W;
   localparam int MC_W    = ERR_W + NUM_W;
   localparam int PROD_W  = MC_W + GAIN_W;
   localparam int SAT_W   = ((IW > INC_W) ? IW : INC_W) + 2;
   localparam int SUM_W   = ((IW > PROD_W) ? IW : PROD_W) + 2;
   localparam int WS_W    = SUM_W - Q_FRAC;

   // long division in 16-bit digits, each digit by reciprocal multiplication
   localparam int CHUNK_W = 16;
   localparam int NCHUNK  = (PROD_W + CHUNK_W - 1) / CHUNK_W;
   localparam int DIVD_W  = NCHUNK * CHUNK_W;
   localparam int REM_W   = $clog2(P_DEN + 1);
   localparam int V_W     = REM_W + CHUNK_W;
   localparam int RCP_SH  = CHUNK_W + 2 * REM_W;
   localparam int RCP_W   = RCP_SH - $clog2(P_DEN) + 1;
   localparam int QP_W    = V_W + RCP_W;
   localparam int CNT_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

   localparam longint RCP_L = ((longint'(1) <<< RCP_SH) + longint'(P_DEN) - 1)
                              / longint'(P_DEN);
   localparam logic [RCP_W-1:0] RCP      = RCP_W'(RCP_L);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCHUNK - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_HOLD = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [ERR_W-1:0]        mag_ff, mag_in;
   logic [INC_W-1:0]        inc_ff, inc_in;
   logic [MC_W-1:0]         mc_ff, mc_in;
   logic                    zero_ff, zero_in;
   logic [IW-1:0]           integ_ff, integ_in;
   logic [DIVD_W-1:0]       div_ff, div_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SPD_W-1:0]        speed_ff, speed_in;

   logic [ERR_W-1:0]        whole_c;
   logic [INC_W-1:0]        prod_i_c;
   logic [SAT_W-1:0]        integ_sx_sat;
   logic [SAT_W-1:0]        acc_sum_c;
   logic                    acc_fits_c;
   logic [IW-1:0]           integ_sat_c;
   logic [PROD_W-1:0]       prod_p_c;
   logic [V_W-1:0]          v_c;
   logic [QP_W-1:0]         qprod_c;
   logic [CHUNK_W-1:0]      qd_c;
   logic [V_W-1:0]          qmul_c;
   logic [REM_W-1:0]        rem_next_c;
   logic [SUM_W-1:0]        integ_sx_sum;
   logic [SUM_W-1:0]        sum_c;
   logic [WS_W-1:0]         sum_whole_c;
   logic [SPD_W-1:0]        speed_c;

   // whole degrees, integral increment and saturating accumulate
   always_comb begin
      whole_c      = mag_ff >> ANGLE_FRAC_BITS;
      prod_i_c     = INC_W'(mag_ff) * INC_W'(ki);
      integ_sx_sat = {{(SAT_W - IW){integ_ff[IW-1]}}, integ_ff};
      acc_sum_c    = err_ff[ERR_W-1] ? (integ_sx_sat - SAT_W'(inc_ff))
                                     : (integ_sx_sat + SAT_W'(inc_ff));
      acc_fits_c   = (&acc_sum_c[SAT_W-1:IW-1]) | ~(|acc_sum_c[SAT_W-1:IW-1]);
      if (acc_fits_c) begin
         integ_sat_c = acc_sum_c[IW-1:0];
      end else if (acc_sum_c[SAT_W-1]) begin
         integ_sat_c = {1'b1, {(IW - 1){1'b0}}};
      end else begin
         integ_sat_c = {1'b0, {(IW - 1){1'b1}}};
      end
   end

   // proportional product and one digit step of the constant division
   always_comb begin
      prod_p_c   = PROD_W'(mc_ff) * PROD_W'(kp);
      v_c        = {rem_ff, div_ff[DIVD_W-1 -: CHUNK_W]};
      qprod_c    = QP_W'(v_c) * QP_W'(RCP);
      qd_c       = qprod_c[RCP_SH +: CHUNK_W];
      qmul_c     = V_W'(qd_c) * V_W'(P_DEN);
      rem_next_c = REM_W'(v_c - qmul_c);
   end

   // speed: p term plus integral, floored at zero, clamped, deadband
   always_comb begin
      integ_sx_sum = {{(SUM_W - IW){integ_ff[IW-1]}}, integ_ff};
      sum_c        = SUM_W'(div_ff) + integ_sx_sum;
      sum_whole_c  = sum_c[SUM_W-1:Q_FRAC];
      if (zero_ff || sum_c[SUM_W-1] || (sum_c == '0)) begin
         speed_c = '0;
      end else if (sum_whole_c >= WS_W'(SPEED_LIMIT)) begin
         speed_c = SPD_W'(SPEED_LIMIT);
      end else begin
         speed_c = sum_c[Q_FRAC +: SPD_W];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      mag_in   = mag_ff;
      inc_in   = inc_ff;
      mc_in    = mc_ff;
      zero_in  = zero_ff;
      integ_in = integ_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      speed_in = speed_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               err_in   = start_err;
               mag_in   = err_mag(start_err);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            inc_in   = prod_i_c >> ANGLE_FRAC_BITS;
            mc_in    = MC_W'(whole_c) * MC_W'(P_NUM);
            zero_in  = (whole_c == '0);
            state_in = S_ACC;
         end
         S_ACC: begin
            integ_in = integ_sat_c;
            div_in   = DIVD_W'(prod_p_c);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_in = {div_ff[DIVD_W-CHUNK_W-1:0], qd_c};
            rem_in = rem_next_c;
            cnt_in = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_LAST) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            speed_in = speed_c;
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and integrator
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         integ_ff <= '0;
      end else begin
         state_ff <= state_in;
         integ_ff <= integ_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      mag_ff   <= mag_in;
      inc_ff   <= inc_in;
      mc_ff    <= mc_in;
      zero_ff  <= zero_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      speed_ff <= speed_in;
   end

   assign res.valid = (state_ff == S_HOLD);
   assign res.speed = speed_ff;
   assign res.err   = err_ff;

endmodule

// ----- rtl/dapt_merge.sv -----
// dapt_merge: combines both lane results into one transaction - direction
// codes, aligned flag - and holds it in the output register. Uses dapt_pkg.
`timescale 1ns / 1ps

module dapt_merge #(
   parameter int ANGLE_FRAC_BITS = dapt_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dapt_pkg::lane_res_type                az_res,
   input  dapt_pkg::lane_res_type                pt_res,
   output logic                                  take,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [dapt_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);
   import dapt_pkg::*;

   localparam int DEG  = 1 << ANGLE_FRAC_BITS;
   localparam int HALF = HALF_TURN_DEG * DEG;
   localparam int PAD_W = RSP_TDATA_W - RSP_ALIGN_BIT - 1;

   logic                   valid_ff, valid_in;
   logic [RSP_TDATA_W-1:0] data_ff, data_in;

   int                     az_e, pt_e;
   logic [DIR_W-1:0]       az_dir_c, pt_dir_c;
   logic [ERR_W-1:0]       az_whole_c, pt_whole_c;
   logic                   aligned_c;

   // direction: azimuth takes the short way round the half turn
   always_comb begin
      az_e     = int'($signed(az_res.err));
      pt_e     = int'($signed(pt_res.err));
      az_dir_c = DIR_NONE;
      if (az_e > DEG) begin
         if (az_e < HALF) begin
            az_dir_c = DIR_BACK;
         end else if (az_e > HALF) begin
            az_dir_c = DIR_FWD;
         end
      end else if (az_e < -DEG) begin
         if (az_e > -HALF) begin
            az_dir_c = DIR_FWD;
         end else if (az_e < -HALF) begin
            az_dir_c = DIR_BACK;
         end
      end
      pt_dir_c = DIR_NONE;
      if (pt_e > DEG) begin
         pt_dir_c = DIR_FWD;
      end else if (pt_e < -DEG) begin
         pt_dir_c = DIR_BACK;
      end
   end

   // aligned when both whole-degree errors are small
   always_comb begin
      az_whole_c = err_mag(az_res.err) >> ANGLE_FRAC_BITS;
      pt_whole_c = err_mag(pt_res.err) >> ANGLE_FRAC_BITS;
      aligned_c  = (az_whole_c < ERR_W'(ALIGN_DEG)) && (pt_whole_c < ERR_W'(ALIGN_DEG));
   end

   // output register loads when both lanes are done and the slot is empty or its result is being taken
   always_comb begin
      take     = az_res.valid && pt_res.valid && (!valid_ff || rsp_tready);
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = {{PAD_W{1'b0}}, aligned_c, pt_res.speed, pt_dir_c,
                     az_res.speed, az_dir_c};
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ----- rtl/dapt_checker.sv -----
// dapt_checker: port-level checks on the tracking controller over time,
// bound to the top level. Uses dapt_pkg.
`timescale 1ns / 1ps

module dapt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [dapt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import dapt_pkg::*;

   logic [1:0] pending_ff, pending_in;

   // items accepted whose result has not been taken yet
   always_comb begin
      pending_in = pending_ff + 2'(req_tvalid && req_tready) - 2'(rsp_tvalid && rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // every result comes from an accepted item
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("response without an outstanding request");

   // at most one item in the lanes and one in the output register
   a_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many outstanding transactions");

   // pitch speed stays within its limit
   a_pitch_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_PT_SPD_LSB +: SPD_W] <= SPD_W'(PT_SPEED_MAX))
      else $error("pitch speed above limit");

endmodule

bind dual_axis_pi_tracking_controller dapt_checker u_dapt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/dual_axis_pi_tracking_controller_tb.sv -----
// dual_axis_pi_tracking_controller_tb: self-checking bench for the pi tracking controller.
// Drives angle transactions under several gain settings, predicts every drive command
// and compares it with the response stream. Depends on dapt_pkg and the controller rtl.
`timescale 1ns / 1ps

module dual_axis_pi_tracking_controller_tb;
   import dapt_pkg::*;

   localparam int     DEG             = 1 << ANGLE_FRAC_BITS_DEF;
   localparam int     INTEG_W         = INTEGRAL_WIDTH_DEF;
   localparam int     NUM_PHASES      = 10;
   localparam int     ITEMS_PER_PHASE = 60;
   localparam int     SETTLE_CYCLES   = 70;
   localparam longint CYCLE_LIMIT     = 1000000;

   // one drive command as the block reports it
   typedef struct {
      logic [DIR_W-1:0] az_dir;
      logic [SPD_W-1:0] az_speed;
      logic [DIR_W-1:0] pt_dir;
      logic [SPD_W-1:0] pt_speed;
      logic             aligned;
   } drive_cmd_type;

   // gain registers, both integrators and the commands still owed by the block
   class pi_drive_scoreboard;
      logic [GAIN_W-1:0] kp_az, ki_az, kp_pt, ki_pt;
      longint            az_offset;
      longint            az_integral, pt_integral;
      drive_cmd_type     expected_cmds[$];
      int                failures;

      function new();
         kp_az       = KP_AZ_RESET;
         ki_az       = KI_AZ_RESET;
         kp_pt       = KP_PT_RESET;
         ki_pt       = KI_PT_RESET;
         az_offset   = OFFSET_RESET;
         az_integral = 0;
         pt_integral = 0;
         failures    = 0;
      endfunction

      function void load_register(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
         logic signed [OFFSET_W-1:0] off;
         off = value[OFFSET_W-1:0];
         case (idx)
            CSR_KP_AZ:  kp_az = value;
            CSR_KI_AZ:  ki_az = value;
            CSR_KP_PT:  kp_pt = value;
            CSR_KI_PT:  ki_pt = value;
            CSR_OFFSET: az_offset = off;
            default: ;
         endcase
      endfunction

      // one saturating integrator step, increment is sign(e) * |e| * ki / deg
      function longint integrate(longint acc, longint e, logic [GAIN_W-1:0] ki);
         longint hi, lo, inc, mag_e, ki_l;
         hi    = (longint'(1) <<< (INTEG_W - 1)) - 1;
         lo    = -hi - 1;
         ki_l  = ki;
         mag_e = (e < 0) ? -e : e;
         inc   = (mag_e * ki_l) >>> ANGLE_FRAC_BITS_DEF;
         if (e >= 0)
            return (hi - acc < inc) ? hi : acc + inc;
         return (acc - lo < inc) ? lo : acc - inc;
      endfunction

      // p plus integral in q24, deadband, negative floor and clamp
      function logic [SPD_W-1:0] drive_speed(longint p, longint integ, longint whole,
                                             longint limit);
         longint s;
         s = p + integ;
         if (whole == 0 || s <= 0)
            return '0;
         s = s >>> Q_FRAC;
         return SPD_W'((s > limit) ? limit : s);
      endfunction

      function void note_request(logic [REQ_TDATA_W-1:0] d);
         logic [AZ_W-1:0]           ta, sa;
         logic signed [PITCH_W-1:0] tp, sp;
         longint                    ta_l, sa_l, ea, ep, ma, mp, pa, pp, kpa_l, kpp_l;
         drive_cmd_type             c;
         ta    = d[REQ_TGT_AZ_LSB +: AZ_W];
         sa    = d[REQ_STD_AZ_LSB +: AZ_W];
         tp    = d[REQ_TGT_PT_LSB +: PITCH_W];
         sp    = d[REQ_STD_PT_LSB +: PITCH_W];
         ta_l  = ta;
         sa_l  = sa;
         kpa_l = kp_az;
         kpp_l = kp_pt;
         ea    = ta_l - sa_l + az_offset;
         ep    = longint'(tp) - longint'(sp);
         ma    = ((ea < 0) ? -ea : ea) >>> ANGLE_FRAC_BITS_DEF;
         mp    = ((ep < 0) ? -ep : ep) >>> ANGLE_FRAC_BITS_DEF;

         az_integral = integrate(az_integral, ea, ki_az);
         pt_integral = integrate(pt_integral, ep, ki_pt);

         pa = ma * AZ_P_NUM * kpa_l / AZ_P_DEN;
         pp = mp * PT_P_NUM * kpp_l / PT_P_DEN;

         // azimuth goes the short way round the half-turn point
         c.az_dir = DIR_NONE;
         if (ea > DEG) begin
            if (ea < HALF_TURN_DEG * DEG)
               c.az_dir = DIR_BACK;
            else if (ea > HALF_TURN_DEG * DEG)
               c.az_dir = DIR_FWD;
         end else if (ea < -DEG) begin
            if (ea > -HALF_TURN_DEG * DEG)
               c.az_dir = DIR_FWD;
            else if (ea < -HALF_TURN_DEG * DEG)
               c.az_dir = DIR_BACK;
         end

         c.pt_dir = DIR_NONE;
         if (ep > DEG)
            c.pt_dir = DIR_FWD;
         else if (ep < -DEG)
            c.pt_dir = DIR_BACK;

         c.az_speed = drive_speed(pa, az_integral, ma, AZ_SPEED_MAX);
         c.pt_speed = drive_speed(pp, pt_integral, mp, PT_SPEED_MAX);
         c.aligned  = (ma < ALIGN_DEG && mp < ALIGN_DEG);
         expected_cmds.push_back(c);
      endfunction

      function void flag_field(string field, int exp_v, int act_v);
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
         failures++;
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] d);
         drive_cmd_type exp_c, got;
         got.az_dir   = d[RSP_AZ_DIR_LSB +: DIR_W];
         got.az_speed = d[RSP_AZ_SPD_LSB +: SPD_W];
         got.pt_dir   = d[RSP_PT_DIR_LSB +: DIR_W];
         got.pt_speed = d[RSP_PT_SPD_LSB +: SPD_W];
         got.aligned  = d[RSP_ALIGN_BIT];
         if (expected_cmds.size() == 0) begin
            $display("%0t: response with nothing expected, expected none actual %h",
                     $time, d);
            failures++;
            return;
         end
         exp_c = expected_cmds.pop_front();
         if (got.az_dir !== exp_c.az_dir)
            flag_field("azimuth_direction", exp_c.az_dir, got.az_dir);
         if (got.az_speed !== exp_c.az_speed)
            flag_field("azimuth_speed", exp_c.az_speed, got.az_speed);
         if (got.pt_dir !== exp_c.pt_dir)
            flag_field("pitch_direction", exp_c.pt_dir, got.pt_dir);
         if (got.pt_speed !== exp_c.pt_speed)
            flag_field("pitch_speed", exp_c.pt_speed, got.pt_speed);
         if (got.aligned !== exp_c.aligned)
            flag_field("aligned", exp_c.aligned, got.aligned);
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // target_azimuth, stand_azimuth, target_pitch, stand_pitch, zero pad
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // azimuth_direction, azimuth_speed, pitch_direction, pitch_speed, aligned, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [GAIN_W-1:0]      csr_wdata  = '0;

   pi_drive_scoreboard     sb;
   longint                 cycle_count = 0;
   int unsigned            ready_hold  = 0;
   int unsigned            ready_mode  = 0;

   dual_axis_pi_tracking_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dual_axis_pi_tracking_controller_tb NOT OK");
         $finish;
      end
   end

   // response side: check each transaction, then pick the next ready pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
      if (ready_hold == 0) begin
         // 0, 1 steady ready, 2 flicker, 3 stall
         ready_mode = $urandom_range(0, 3);
         ready_hold = (ready_mode == 3) ? $urandom_range(1, 150) : $urandom_range(20, 200);
      end else begin
         ready_hold--;
      end
      rsp_tready <= (ready_mode == 3) ? 1'b0 :
                    (ready_mode == 2) ? 1'($urandom_range(0, 1)) : 1'b1;
   end

   // one request transaction, returns at the accepting edge
   task automatic send_angles(input int ta, input int sa, input int tp, input int sp);
      logic [REQ_TDATA_W-1:0] d;
      d = '0;
      d[REQ_TGT_AZ_LSB +: AZ_W]    = AZ_W'(ta);
      d[REQ_STD_AZ_LSB +: AZ_W]    = AZ_W'(sa);
      d[REQ_TGT_PT_LSB +: PITCH_W] = PITCH_W'(tp);
      d[REQ_STD_PT_LSB +: PITCH_W] = PITCH_W'(sp);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(d);
   endtask

   // hold the sender until every owed command is back, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_cmds.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.load_register(idx, value);
   endtask

   initial begin
      int                burst_left, gap, kind, offset, ta, sa, tp, sp;
      logic [GAIN_W-1:0] kp_a, ki_a, kp_p, ki_p;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset gains with a 10 degree azimuth offset
      send_angles(0, 0, 0, 0);
      send_angles(0, 1280, 0, 0);            // zero error
      send_angles(0, 1153, 0, 0);            // just inside the deadband
      send_angles(0, 1152, 0, 128);          // exactly one degree, no direction
      send_angles(0, 1151, 129, 0);          // just past one degree
      send_angles(0, 1408, 0, 129);          // minus one degree and just past
      send_angles(0, 1409, 128, 0);
      send_angles(0, 897, 383, 0);           // last aligned value
      send_angles(0, 896, 0, 384);           // first unaligned value
      send_angles(21760, 0, 0, 0);           // exactly half a turn
      send_angles(21761, 0, 0, 0);
      send_angles(0, 24320, 0, 0);           // exactly minus half a turn
      send_angles(0, 24321, 0, 0);
      send_angles(46079, 0, 11520, -11520);  // field extremes in range
      send_angles(0, 46079, -11520, 11520);
      send_angles(65535, 0, 16383, -16384);  // full field width
      send_angles(0, 65535, -16384, 16383);
      send_angles(65535, 65535, -1, -1);
      wait_idle();

      for (int p = 1; p <= NUM_PHASES; p++) begin
         // gain settings, fixed extremes first, then random ones
         case (p)
            1: begin
               {kp_a, ki_a, kp_p, ki_p} = '0;
               offset = 0;
            end
            2: begin
               {kp_a, ki_a, kp_p, ki_p} = '1;
               offset = 46080;
            end
            3: begin
               kp_a = '1;  ki_a = 32'd65536;
               kp_p = '0;  ki_p = '1;
               offset = -46080;
            end
            4: begin
               kp_a = 32'd16777216;  ki_a = 32'd262144;
               kp_p = 32'd8388608;   ki_p = 32'd262144;
               offset = -65536;
            end
            5: begin
               kp_a = KP_AZ_RESET;  ki_a = 32'd131072;
               kp_p = KP_PT_RESET;  ki_p = 32'd4096;
               offset = 65535;
            end
            default: begin
               kp_a = $urandom_range(0, 32'h1400_0000);
               ki_a = $urandom_range(0, 32'h0010_0000);
               kp_p = $urandom_range(0, 32'h1400_0000);
               ki_p = $urandom_range(0, 32'h0010_0000);
               offset = int'($urandom_range(0, 92160)) - 46080;
            end
         endcase
         write_reg(CSR_KP_AZ, kp_a);
         write_reg(CSR_KI_AZ, ki_a);
         write_reg(CSR_KP_PT, kp_p);
         write_reg(CSR_KI_PT, ki_p);
         write_reg(CSR_OFFSET, GAIN_W'(offset));
         csr_we <= 1'b0;

         burst_left = $urandom_range(0, 25);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
               // anywhere in the working range
               ta = $urandom_range(0, 46079);
               sa = $urandom_range(0, 46079);
               tp = int'($urandom_range(0, 23040)) - 11520;
               sp = int'($urandom_range(0, 23040)) - 11520;
            end else if (kind < 8) begin
               // close to alignment, around deadband and aligned limits
               ta = $urandom_range(0, 46079);
               sa = ta + int'(sb.az_offset) + int'($urandom_range(0, 1200)) - 600;
               tp = int'($urandom_range(0, 23040)) - 11520;
               sp = tp + int'($urandom_range(0, 1200)) - 600;
            end else begin
               // any bit pattern
               ta = $urandom;
               sa = $urandom;
               tp = $urandom;
               sp = $urandom;
            end
            send_angles(ta, sa, tp, sp);

            // bursts and gaps, every third phase streams without gaps
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               gap = (p % 3 == 0) ? 0 : $urandom_range(1, 30);
               if (gap > 0) begin
                  req_tvalid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(0, 25);
            end
         end
         wait_idle();
      end

      if (sb.failures == 0 && sb.expected_cmds.size() == 0)
         $display("dual_axis_pi_tracking_controller_tb OK");
      else
         $display("dual_axis_pi_tracking_controller_tb NOT OK");
      $finish;
   end

endmodule

// ----- dual_axis_pi_tracking_controller.f -----
rtl/dapt_pkg.sv
rtl/dapt_lane.sv
rtl/dapt_merge.sv
rtl/dual_axis_pi_tracking_controller.sv
rtl/dapt_checker.sv
tb/dual_axis_pi_tracking_controller_tb.sv
